/* src/plim_pkg.sv */
`default_nettype none
package plim_pkg;

    localparam logic [1:0] REG_EINSTEIN = 2'd0;
    localparam logic [1:0] REG_KL       = 2'd1;
    localparam logic [1:0] REG_APPARENT = 2'd2;
    localparam logic [1:0] REG_OFFSET   = 2'd3;

    localparam logic [5:0]  RST_EINSTEIN = 6'd30;
    localparam logic [6:0]  RST_KL       = 7'd50;
    localparam logic [17:0] RST_APPARENT = 18'd15360;
    localparam logic [17:0] RST_OFFSET   = 18'd7680;

    localparam logic [6:0] KL_MIN = 7'd30;

    // floor(x/25) = (x * RECIP_25) >> RECIP_SHIFT for x below 2^29
    localparam logic [29:0] RECIP_25    = 30'd687194768;
    localparam int          RECIP_SHIFT = 34;

    localparam int LNS_NW = 62;
    localparam int LNS_DW = 49;
    localparam int LNS_QW = 37;
    localparam int POS_NW = 46;
    localparam int POS_DW = 12;
    localparam int POS_QW = 35;

    typedef struct packed {
        logic [5:0]  e;
        logic [6:0]  k;
        logic [17:0] a;
        logic [17:0] r;
    } plim_cfg_t;

    typedef struct packed {
        logic                valid;
        logic                sing;
        logic                su;
        logic                sy;
        logic [23:0]         xq;
        logic [23:0]         yq;
        logic [LNS_NW-1:0]   nw;
        logic [LNS_NW-1:0]   nv;
        logic [LNS_NW-1:0]   nc;
        logic [LNS_DW-1:0]   dw;
        logic [LNS_DW-1:0]   dc;
    } plim_lens_t;

    typedef struct packed {
        logic                valid;
        logic                sing;
        logic                su;
        logic                sy;
        logic [23:0]         xq;
        logic [23:0]         yq;
        logic [LNS_QW-1:0]   qw;
        logic [LNS_QW-1:0]   qv;
        logic [LNS_QW-1:0]   qc;
    } plim_mid_t;

    typedef struct packed {
        logic        valid;
        logic [8:0]  src_row;
        logic [9:0]  src_col;
        logic        in_range;
        logic        singular;
    } plim_res_t;

    function automatic logic [6:0] kl_clamp(input logic [6:0] k);
        return (k < KL_MIN) ? KL_MIN : k;
    endfunction

endpackage
`default_nettype wire

/* src/plim_if.sv */
`default_nettype none
interface plim_pix_if;
    logic       valid;
    logic       ready;
    logic [8:0] pixel_row;
    logic [9:0] pixel_col;
    modport source (output valid, pixel_row, pixel_col, input ready);
    modport sink (input valid, pixel_row, pixel_col, output ready);
endinterface

interface plim_map_if;
    logic       valid;
    logic       ready;
    logic [8:0] src_row;
    logic [9:0] src_col;
    logic       in_range;
    logic       singular;
    modport source (output valid, src_row, src_col, in_range, singular, input ready);
    modport sink (input valid, src_row, src_col, in_range, singular, output ready);
endinterface
`default_nettype wire

/* src/plim_cfg.sv */
`default_nettype none
module plim_cfg (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [3:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    output plim_pkg::plim_cfg_t      cfg
);

    plim_pkg::plim_cfg_t cfg_reg;
    logic                wr;

    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.e <= plim_pkg::RST_EINSTEIN;
            cfg_reg.k <= plim_pkg::RST_KL;
            cfg_reg.a <= plim_pkg::RST_APPARENT;
            cfg_reg.r <= plim_pkg::RST_OFFSET;
        end
        else if (wr)
        begin
            unique case (paddr[3:2])
                plim_pkg::REG_EINSTEIN: cfg_reg.e <= pwdata[5:0];
                plim_pkg::REG_KL:       cfg_reg.k <= pwdata[6:0];
                plim_pkg::REG_APPARENT: cfg_reg.a <= pwdata[17:0];
                plim_pkg::REG_OFFSET:   cfg_reg.r <= pwdata[17:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            plim_pkg::REG_EINSTEIN: prdata = {26'b0, cfg_reg.e};
            plim_pkg::REG_KL:       prdata = {25'b0, cfg_reg.k};
            plim_pkg::REG_APPARENT: prdata = {14'b0, cfg_reg.a};
            plim_pkg::REG_OFFSET:   prdata = {14'b0, cfg_reg.r};
        endcase
    end

endmodule
`default_nettype wire

/* src/plim_div.sv */
`default_nettype none
module plim_div #(
    parameter int NW = 62,
    parameter int DW = 49,
    parameter int QW = 37,
    parameter int SW = 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    input  wire logic [SW-1:0] sb_in,
    output logic [QW-1:0]      quo,
    output logic [SW-1:0]      sb_out
);

    localparam int HW = NW - QW;

    logic [DW-1:0] r_reg  [QW-1];
    logic [QW-1:0] l_reg  [QW-1];
    logic [DW-1:0] d_reg  [QW-1];
    logic [QW-1:0] q_reg  [QW];
    logic [SW-1:0] sb_reg [QW];

    logic [DW-1:0] r_in   [QW];
    logic [QW-1:0] l_in   [QW];
    logic [DW-1:0] d_in   [QW];
    logic [QW-1:0] q_in   [QW];
    logic [SW-1:0] sb_src [QW];
    logic [DW:0]   rs     [QW];
    logic [DW:0]   df     [QW];
    logic          ge     [QW];

    genvar s;
    generate
        for (s = 0; s < QW; s++)
        begin : g_stage
            if (s == 0)
            begin : g_first
                assign r_in[s]   = {{(DW-HW){1'b0}}, num[NW-1:QW]};
                assign l_in[s]   = num[QW-1:0];
                assign d_in[s]   = den;
                assign q_in[s]   = '0;
                assign sb_src[s] = sb_in;
            end
            else
            begin : g_rest
                assign r_in[s]   = r_reg[s-1];
                assign l_in[s]   = l_reg[s-1];
                assign d_in[s]   = d_reg[s-1];
                assign q_in[s]   = q_reg[s-1];
                assign sb_src[s] = sb_reg[s-1];
            end

            assign rs[s] = {r_in[s], l_in[s][QW-1]};
            assign df[s] = rs[s] - {1'b0, d_in[s]};
            assign ge[s] = rs[s] >= {1'b0, d_in[s]};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    q_reg[s] <= {q_in[s][QW-2:0], ge[s]};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sb_reg[s] <= '0;
                end
                else if (en)
                begin
                    sb_reg[s] <= sb_src[s];
                end
            end

            if (s < QW - 1)
            begin : g_carry
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        r_reg[s] <= ge[s] ? df[s][DW-1:0] : rs[s][DW-1:0];
                        l_reg[s] <= {l_in[s][QW-2:0], 1'b0};
                        d_reg[s] <= d_in[s];
                    end
                end
            end
        end
    endgenerate

    assign quo    = q_reg[QW-1];
    assign sb_out = sb_reg[QW-1];

endmodule
`default_nettype wire

/* src/plim_front.sv */
`default_nettype none
module plim_front #(
    parameter int IMG_ROWS = 512,
    parameter int IMG_COLS = 1024
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire plim_pkg::plim_cfg_t  cfg,
    input  wire logic                 vin,
    input  wire logic [8:0]           pixel_row,
    input  wire logic [9:0]           pixel_col,
    output plim_pkg::plim_lens_t      lens
);

    localparam logic signed [20:0] CX = 21'(128 * IMG_COLS);
    localparam logic signed [20:0] CY = 21'(128 * IMG_ROWS);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;

    logic signed [28:0] mx1_reg, my1_reg;
    logic               sx2_reg, sy2_reg, sx3_reg, sy3_reg;
    logic [28:0]        x2_reg, y2_reg;
    logic [58:0]        px3_reg, py3_reg;
    logic signed [23:0] xq4_reg, yq4_reg, xq5_reg, yq5_reg, xq6_reg, yq6_reg;
    logic signed [23:0] xq7_reg, yq7_reg;
    logic signed [24:0] u5_reg;
    logic [47:0]        usq6_reg, ysq6_reg, d7_reg;
    logic [23:0]        au6_reg, ay6_reg;
    logic [11:0]        e26_reg, e27_reg;
    logic               su6_reg, sy6_reg, su7_reg, sy7_reg;
    logic [35:0]        nu7_reg, nv7_reg;
    plim_pkg::plim_lens_t lens_reg;

    logic signed [20:0] tx, ty;
    logic signed [7:0]  ks;
    logic signed [28:0] mx_next, my_next, amx, amy;
    logic [31:0]        xv, yv;
    logic [58:0]        px_next, py_next;
    logic [24:0]        qx, qy;
    logic signed [23:0] xq_next, yq_next;
    logic signed [24:0] u_next, au_w, ay_w;
    logic signed [49:0] usq_w;
    logic signed [47:0] ysq_w;
    logic [47:0]        d_next;
    logic [35:0]        nu_next, nv_next;

    assign ks = $signed({1'b0, plim_pkg::kl_clamp(cfg.k)});
    assign tx = $signed({3'b0, pixel_col, 8'b0}) - $signed({3'b0, cfg.a}) - CX;
    assign ty = CY - $signed({4'b0, pixel_row, 8'b0});
    assign mx_next = 29'(tx * ks);
    assign my_next = 29'(ty * ks);

    assign amx = mx1_reg[28] ? -mx1_reg : mx1_reg;
    assign amy = my1_reg[28] ? -my1_reg : my1_reg;
    assign xv  = {amx[26:0], 5'b0} + 32'd100;
    assign yv  = {amy[26:0], 5'b0} + 32'd100;

    assign px_next = 59'(x2_reg * plim_pkg::RECIP_25);
    assign py_next = 59'(y2_reg * plim_pkg::RECIP_25);

    assign qx = px3_reg[58:plim_pkg::RECIP_SHIFT];
    assign qy = py3_reg[58:plim_pkg::RECIP_SHIFT];

    always_comb
    begin
        if (sx3_reg)
        begin
            xq_next = (qx >= 25'd8388608) ? 24'h800000 : 24'(25'd0 - qx);
        end
        else
        begin
            xq_next = (qx >= 25'd8388607) ? 24'h7FFFFF : qx[23:0];
        end
        if (sy3_reg)
        begin
            yq_next = (qy >= 25'd8388608) ? 24'h800000 : 24'(25'd0 - qy);
        end
        else
        begin
            yq_next = (qy >= 25'd8388607) ? 24'h7FFFFF : qy[23:0];
        end
    end

    assign u_next = $signed({xq4_reg[23], xq4_reg}) + $signed({3'b0, cfg.r, 4'b0});

    assign usq_w = 50'(u5_reg * u5_reg);
    assign ysq_w = 48'(yq5_reg * yq5_reg);
    assign au_w  = u5_reg[24] ? -u5_reg : u5_reg;
    assign ay_w  = yq5_reg[23] ? -$signed({yq5_reg[23], yq5_reg})
                               : $signed({yq5_reg[23], yq5_reg});

    assign d_next  = usq6_reg + ysq6_reg;
    assign nu_next = 36'(e26_reg * au6_reg);
    assign nv_next = 36'(e26_reg * ay6_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            v4_reg         <= 1'b0;
            v5_reg         <= 1'b0;
            v6_reg         <= 1'b0;
            v7_reg         <= 1'b0;
            lens_reg       <= '0;
        end
        else if (en)
        begin
            v1_reg         <= vin;
            v2_reg         <= v1_reg;
            v3_reg         <= v2_reg;
            v4_reg         <= v3_reg;
            v5_reg         <= v4_reg;
            v6_reg         <= v5_reg;
            v7_reg         <= v6_reg;
            lens_reg.valid <= v7_reg;

            lens_reg.sing <= (cfg.r == 18'd0) || (d7_reg == 48'd0);
            lens_reg.su   <= su7_reg;
            lens_reg.sy   <= sy7_reg;
            lens_reg.xq   <= xq7_reg;
            lens_reg.yq   <= yq7_reg;
            lens_reg.nw   <= {1'b0, nu7_reg, 25'b0} + {14'b0, d7_reg};
            lens_reg.nv   <= {1'b0, nv7_reg, 25'b0} + {14'b0, d7_reg};
            lens_reg.nc   <= {25'b0, e27_reg, 25'b0} + {40'b0, cfg.r, 4'b0};
            lens_reg.dw   <= {d7_reg, 1'b0};
            lens_reg.dc   <= {26'b0, cfg.r, 5'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx1_reg  <= mx_next;
            my1_reg  <= my_next;

            sx2_reg  <= mx1_reg[28];
            sy2_reg  <= my1_reg[28];
            x2_reg   <= xv[31:3];
            y2_reg   <= yv[31:3];

            sx3_reg  <= sx2_reg;
            sy3_reg  <= sy2_reg;
            px3_reg  <= px_next;
            py3_reg  <= py_next;

            xq4_reg  <= xq_next;
            yq4_reg  <= yq_next;

            u5_reg   <= u_next;
            xq5_reg  <= xq4_reg;
            yq5_reg  <= yq4_reg;

            usq6_reg <= usq_w[47:0];
            ysq6_reg <= ysq_w;
            au6_reg  <= au_w[23:0];
            ay6_reg  <= ay_w[23:0];
            e26_reg  <= 12'(cfg.e * cfg.e);
            xq6_reg  <= xq5_reg;
            yq6_reg  <= yq5_reg;
            su6_reg  <= u5_reg[24];
            sy6_reg  <= yq5_reg[23];

            d7_reg   <= d_next;
            nu7_reg  <= nu_next;
            nv7_reg  <= nv_next;
            e27_reg  <= e26_reg;
            xq7_reg  <= xq6_reg;
            yq7_reg  <= yq6_reg;
            su7_reg  <= su6_reg;
            sy7_reg  <= sy6_reg;
        end
    end

    assign lens = lens_reg;

endmodule
`default_nettype wire

/* src/plim_back.sv */
`default_nettype none
module plim_back #(
    parameter int IMG_ROWS = 512,
    parameter int IMG_COLS = 1024
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire plim_pkg::plim_cfg_t  cfg,
    input  wire plim_pkg::plim_mid_t  mid,
    output plim_pkg::plim_res_t       res
);

    localparam logic signed [37:0] CBASE   = 38'(128 * IMG_COLS + 128);
    localparam logic signed [37:0] RBASE   = 38'(128 * IMG_ROWS + 128);
    localparam logic signed [37:0] COL_LIM = 38'(256 * IMG_COLS);
    localparam logic signed [37:0] ROW_LIM = 38'(256 * IMG_ROWS);

    localparam int PQ = plim_pkg::POS_QW;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic g1_reg, g2_reg, g3_reg, g4_reg, g5_reg;

    logic signed [23:0] xq1_reg, yq1_reg;
    logic signed [37:0] sw1_reg, sv1_reg, xs2_reg, ys2_reg, tc5_reg, tr5_reg;
    logic [36:0]        qc1_reg, ax3_reg, ay3_reg;
    logic               sx3_reg, sy3_reg, sx4_reg, sy4_reg;
    logic [45:0]        nx4_reg, ny4_reg;
    logic [11:0]        dd4_reg;
    plim_pkg::plim_res_t res_reg;

    logic signed [37:0] qw_s, qv_s, xs_next, ys_next, bc;
    logic [6:0]         kc;
    logic [PQ-1:0]      qx, qy;
    logic [1:0]         sbx_out, sby_out;
    logic               col_ok, row_ok;

    assign kc   = plim_pkg::kl_clamp(cfg.k);
    assign qw_s = $signed({1'b0, mid.qw});
    assign qv_s = $signed({1'b0, mid.qv});

    assign xs_next = $signed({{14{xq1_reg[23]}}, xq1_reg}) + $signed({1'b0, qc1_reg}) - sw1_reg;
    assign ys_next = $signed({{14{yq1_reg[23]}}, yq1_reg}) - sv1_reg;

    plim_div #(
        .NW (plim_pkg::POS_NW),
        .DW (plim_pkg::POS_DW),
        .QW (PQ),
        .SW (2)
    ) u_div_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .num    (nx4_reg),
        .den    (dd4_reg),
        .sb_in  ({v4_reg, sx4_reg}),
        .quo    (qx),
        .sb_out (sbx_out)
    );

    plim_div #(
        .NW (plim_pkg::POS_NW),
        .DW (plim_pkg::POS_DW),
        .QW (PQ),
        .SW (2)
    ) u_div_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .num    (ny4_reg),
        .den    (dd4_reg),
        .sb_in  ({g4_reg, sy4_reg}),
        .quo    (qy),
        .sb_out (sby_out)
    );

    assign bc = $signed({20'b0, cfg.a}) + CBASE;

    assign col_ok = (tc5_reg > 38'sd0) && (tc5_reg < COL_LIM);
    assign row_ok = (tr5_reg > 38'sd0) && (tr5_reg < ROW_LIM);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            res_reg       <= '0;
        end
        else if (en)
        begin
            v1_reg        <= mid.valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= sbx_out[1];
            res_reg.valid <= v5_reg;

            if (g5_reg)
            begin
                res_reg.singular <= 1'b1;
                res_reg.in_range <= 1'b0;
                res_reg.src_row  <= 9'd0;
                res_reg.src_col  <= 10'd0;
            end
            else if (col_ok && row_ok)
            begin
                res_reg.singular <= 1'b0;
                res_reg.in_range <= 1'b1;
                res_reg.src_row  <= tr5_reg[16:8];
                res_reg.src_col  <= tc5_reg[17:8];
            end
            else
            begin
                res_reg.singular <= 1'b0;
                res_reg.in_range <= 1'b0;
                res_reg.src_row  <= 9'd0;
                res_reg.src_col  <= 10'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g1_reg  <= mid.sing;
            xq1_reg <= mid.xq;
            yq1_reg <= mid.yq;
            qc1_reg <= mid.qc;
            sw1_reg <= mid.su ? -qw_s : qw_s;
            sv1_reg <= mid.sy ? -qv_s : qv_s;

            g2_reg  <= g1_reg;
            xs2_reg <= xs_next;
            ys2_reg <= ys_next;

            g3_reg  <= g2_reg;
            sx3_reg <= xs2_reg[37];
            sy3_reg <= ys2_reg[37];
            ax3_reg <= xs2_reg[37] ? 37'(-xs2_reg) : xs2_reg[36:0];
            ay3_reg <= ys2_reg[37] ? 37'(-ys2_reg) : ys2_reg[36:0];

            g4_reg  <= g3_reg;
            sx4_reg <= sx3_reg;
            sy4_reg <= sy3_reg;
            nx4_reg <= {9'b0, ax3_reg} * 46'd200 + {35'b0, kc, 4'b0};
            ny4_reg <= {9'b0, ay3_reg} * 46'd200 + {35'b0, kc, 4'b0};
            dd4_reg <= {kc, 5'b0};

            g5_reg  <= sby_out[1];
            tc5_reg <= sbx_out[0] ? bc - $signed({3'b0, qx}) : bc + $signed({3'b0, qx});
            tr5_reg <= sby_out[0] ? RBASE + $signed({3'b0, qy}) : RBASE - $signed({3'b0, qy});
        end
    end

    assign res = res_reg;

endmodule
`default_nettype wire

/* src/point_lens_inverse_map.sv */
// point_lens_inverse_map
// Inverse mapping of a point-mass lens: for each destination pixel on the
// pix channel it returns, on the map channel, the source pixel to copy from,
// an in-range flag and a singular flag.
// Both channels use valid/ready; a transfer happens when both are high.
// Lens parameters sit in four registers on the APB port (byte addresses
// 0, 4, 8, 12); write them only while no pixel is in flight.
// Throughput: one pixel per clock while map.ready stays high.
// Pipeline: two pipelined restoring dividers, one quotient bit per stage
// (37 stages for the lens terms, 35 for the rescale), plus 14 arithmetic
// stages and the output register.
// When map.ready is low, the next result parks in a skid register and the
// whole pipeline holds until that register drains; pix.ready follows it.
// Reset clears all valid bits and restores the register defaults; no pixel
// is accepted or produced until reset is released.
`default_nettype none
module point_lens_inverse_map #(
    parameter int IMG_ROWS = 512,
    parameter int IMG_COLS = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    plim_pix_if.sink         pix,
    plim_map_if.source       map
);

    localparam int LQ = plim_pkg::LNS_QW;

    plim_pkg::plim_cfg_t  cfg;
    plim_pkg::plim_lens_t lens;
    plim_pkg::plim_mid_t  mid;
    plim_pkg::plim_res_t  res;
    plim_pkg::plim_res_t  out_reg, skid_reg;

    logic          en;
    logic          take;
    logic          out_v_reg, skid_v_reg;
    logic [LQ-1:0] qw, qv, qc;
    logic [25:0]   sbw_out;
    logic [24:0]   sbv_out;
    logic          sbc_out;

    assign en       = !skid_v_reg;
    assign pix.ready = en && rst_n;
    assign take     = out_v_reg && map.ready;

    plim_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    plim_front #(
        .IMG_ROWS (IMG_ROWS),
        .IMG_COLS (IMG_COLS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg),
        .vin       (pix.valid),
        .pixel_row (pix.pixel_row),
        .pixel_col (pix.pixel_col),
        .lens      (lens)
    );

    plim_div #(
        .NW (plim_pkg::LNS_NW),
        .DW (plim_pkg::LNS_DW),
        .QW (LQ),
        .SW (26)
    ) u_div_w (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .num    (lens.nw),
        .den    (lens.dw),
        .sb_in  ({lens.sing, lens.su, lens.xq}),
        .quo    (qw),
        .sb_out (sbw_out)
    );

    plim_div #(
        .NW (plim_pkg::LNS_NW),
        .DW (plim_pkg::LNS_DW),
        .QW (LQ),
        .SW (25)
    ) u_div_v (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .num    (lens.nv),
        .den    (lens.dw),
        .sb_in  ({lens.sy, lens.yq}),
        .quo    (qv),
        .sb_out (sbv_out)
    );

    plim_div #(
        .NW (plim_pkg::LNS_NW),
        .DW (plim_pkg::LNS_DW),
        .QW (LQ),
        .SW (1)
    ) u_div_c (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .num    (lens.nc),
        .den    (lens.dc),
        .sb_in  (lens.valid),
        .quo    (qc),
        .sb_out (sbc_out)
    );

    always_comb
    begin
        mid.valid = sbc_out;
        mid.sing  = sbw_out[25];
        mid.su    = sbw_out[24];
        mid.xq    = sbw_out[23:0];
        mid.sy    = sbv_out[24];
        mid.yq    = sbv_out[23:0];
        mid.qw    = qw;
        mid.qv    = qv;
        mid.qc    = qc;
    end

    plim_back #(
        .IMG_ROWS (IMG_ROWS),
        .IMG_COLS (IMG_COLS)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .cfg   (cfg),
        .mid   (mid),
        .res   (res)
    );

    // load the output register, or park the pipeline result in the skid register when the output holds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (take)
            begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
        end
        else if (!out_v_reg || take)
        begin
            out_v_reg <= res.valid;
        end
        else
        begin
            skid_v_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (!out_v_reg || take)
        begin
            out_reg <= res;
        end
        else
        begin
            skid_reg <= res;
        end
    end

    assign map.valid    = out_v_reg;
    assign map.src_row  = out_reg.src_row;
    assign map.src_col  = out_reg.src_col;
    assign map.in_range = out_reg.in_range;
    assign map.singular = out_reg.singular;

endmodule
`default_nettype wire

/* tb/tb_point_lens_inverse_map.sv */
`default_nettype none
module tb_point_lens_inverse_map;

    localparam int ROWS = 512;
    localparam int COLS = 1024;
    localparam int STALL_LIMIT = 3000;

    typedef struct packed {
        logic [8:0] row;
        logic [9:0] col;
    } pixel_t;

    typedef struct packed {
        logic [8:0] src_row;
        logic [9:0] src_col;
        logic       in_range;
        logic       singular;
    } source_px_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    plim_pix_if pix ();
    plim_map_if map ();

    point_lens_inverse_map #(.IMG_ROWS(ROWS), .IMG_COLS(COLS)) uut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .pix(pix), .map(map)
    );

    logic [5:0]  lens_e = plim_pkg::RST_EINSTEIN;
    logic [6:0]  lens_k = plim_pkg::RST_KL;
    logic [17:0] lens_a = plim_pkg::RST_APPARENT;
    logic [17:0] lens_r = plim_pkg::RST_OFFSET;

    pixel_t     pending_px[$];
    source_px_t expected_src[$];
    bit         quiet = 1'b0;
    bit         pix_took = 1'b0;
    int         send_gap = 0;
    int         recv_gap = 0;
    int         mismatches = 0;
    int         mapped = 0;
    int         hits = 0;
    int         singulars = 0;
    int         stall_cycles = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        pix.valid = 1'b0;
        pix.pixel_row = '0;
        pix.pixel_col = '0;
        map.ready = 1'b0;
    end

    function automatic longint div_round(longint n, longint d);
        if (n >= 0)
            return (2 * n + d) / (2 * d);
        return -((-2 * n + d) / (2 * d));
    endfunction

    function automatic longint clip24(longint v);
        if (v > 64'sd8388607)
            return 64'sd8388607;
        if (v < -64'sd8388608)
            return -64'sd8388608;
        return v;
    endfunction

    function automatic source_px_t trace_back(pixel_t p);
        longint k, a, rq, e2, xq, yq, r12, u, d, c, w, v, xs, ys, xp, yp, cv, rv;
        source_px_t s;
        s = '0;
        k = lens_k;
        if (k < plim_pkg::KL_MIN)
            k = plim_pkg::KL_MIN;
        a = lens_a;
        rq = lens_r;
        e2 = longint'(lens_e) * longint'(lens_e);
        xq = clip24(div_round((256 * longint'(p.col) - a - 128 * COLS) * k * 16, 100));
        yq = clip24(div_round((128 * ROWS - 256 * longint'(p.row)) * k * 16, 100));
        r12 = rq * 16;
        u = xq + r12;
        d = u * u + yq * yq;
        if (rq == 0 || d == 0)
        begin
            s.singular = 1'b1;
            return s;
        end
        c = div_round(e2 * 64'sd16777216, r12);
        w = div_round(e2 * u * 64'sd16777216, d);
        v = div_round(e2 * yq * 64'sd16777216, d);
        xs = xq + c - w;
        ys = yq - v;
        xp = div_round(xs * 100, 16 * k);
        yp = div_round(ys * 100, 16 * k);
        cv = div_round(a + 128 * COLS + xp, 256);
        rv = div_round(128 * ROWS - yp, 256);
        if (rv >= 0 && rv < ROWS && cv >= 0 && cv < COLS)
        begin
            s.src_row = rv[8:0];
            s.src_col = cv[9:0];
            s.in_range = 1'b1;
        end
        return s;
    endfunction

    always @(posedge clk)
    begin
        source_px_t want, got;
        pix_took = rst_n && pix.valid && pix.ready;
        if (pix_took)
            expected_src = {expected_src, trace_back({pix.pixel_row, pix.pixel_col})};
        if (rst_n && map.valid && map.ready)
        begin
            got = {map.src_row, map.src_col, map.in_range, map.singular};
            mapped++;
            hits += got.in_range;
            singulars += got.singular;
            if (expected_src.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: %p", got);
            end
            else
            begin
                want = expected_src.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
        if (pix_took || (map.valid && map.ready) || !rst_n)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        logic   nvalid;
        pixel_t np;
        nvalid = pix.valid;
        np = {pix.pixel_row, pix.pixel_col};
        if (rst_n && (!pix.valid || pix_took))
        begin
            nvalid = 1'b0;
            if (send_gap > 0)
                send_gap--;
            else if (!quiet && $urandom_range(0, 7) == 0)
                send_gap = $urandom_range(1, 10) - 1;
            else if (pending_px.size() > 0)
            begin
                np = pending_px.pop_front();
                nvalid = 1'b1;
            end
        end
        pix.valid <= nvalid;
        {pix.pixel_row, pix.pixel_col} <= np;
    end

    always @(negedge clk)
    begin
        logic nready;
        nready = 1'b1;
        if (recv_gap > 0)
        begin
            recv_gap--;
            nready = 1'b0;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            recv_gap = $urandom_range(1, 10) - 1;
            nready = 1'b0;
        end
        map.ready <= rst_n && nready;
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            plim_pkg::REG_EINSTEIN: lens_e = value[5:0];
            plim_pkg::REG_KL:       lens_k = value[6:0];
            plim_pkg::REG_APPARENT: lens_a = value[17:0];
            default:                lens_r = value[17:0];
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_lens(logic [5:0] e, logic [6:0] k, logic [17:0] a, logic [17:0] r);
        write_reg(plim_pkg::REG_EINSTEIN, 32'(e));
        write_reg(plim_pkg::REG_KL, 32'(k));
        write_reg(plim_pkg::REG_APPARENT, 32'(a));
        write_reg(plim_pkg::REG_OFFSET, 32'(r));
    endtask

    task automatic drain();
        while (pending_px.size() > 0 || pix.valid || expected_src.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic add_px(int row, int col);
        pending_px = {pending_px, pixel_t'({9'(row), 10'(col)})};
    endtask

    task automatic add_random(int n);
        repeat (n)
            add_px($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1));
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        add_px(0, 0);
        add_px(511, 1023);
        add_px(0, 1023);
        add_px(511, 0);
        add_px(256, 512);
        add_px(256, 600);
        add_px(128, 300);
        drain();

        // zero lens offset
        set_lens(6'd30, 7'd50, 18'd15360, 18'd0);
        add_px(10, 20);
        add_px(300, 900);
        drain();

        // zero denominator at row 256, col 600 with KL = 100
        set_lens(6'd20, 7'd100, 18'd30208, 18'd7680);
        add_px(256, 600);
        add_px(256, 599);
        add_px(255, 600);
        drain();

        set_lens(6'd0, 7'd0, 18'd0, 18'd1);
        add_px(0, 0);
        add_px(511, 1023);
        add_random(3);
        drain();
        set_lens(6'd63, 7'd29, 18'h3FFFF, 18'h3FFFF);
        add_px(0, 0);
        add_px(511, 1023);
        add_random(3);
        drain();
        set_lens(6'd60, 7'd127, 18'd40000, 18'd20000);
        add_random(4);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            set_lens(6'($urandom_range(0, 63)), 7'($urandom_range(20, 127)),
                     18'($urandom_range(0, 262143)), 18'($urandom_range(0, 262143)));
            add_random(80);
            drain();
        end
        set_lens(plim_pkg::RST_EINSTEIN, plim_pkg::RST_KL, plim_pkg::RST_APPARENT,
                 plim_pkg::RST_OFFSET);
        add_random(80);
        drain();

        quiet = 1'b1;
        set_lens(6'($urandom_range(10, 50)), 7'($urandom_range(30, 100)),
                 18'($urandom_range(0, 40000)), 18'($urandom_range(1000, 20000)));
        add_random(90);
        drain();

        $display("mapped %0d pixels over 14 lens settings: %0d in range, %0d singular",
                 mapped, hits, singulars);
        if (mismatches == 0)
            $display("== PASS ==");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire
